@@ rtl/six_axis_sliding_median_unit_defines.svh @@
// Assertion macros shared by the six-axis sliding median RTL.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef SIX_AXIS_SLIDING_MEDIAN_UNIT_DEFINES_SVH
`define SIX_AXIS_SLIDING_MEDIAN_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFMU_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SFMU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/sfmu_pkg.sv @@
// Shared constants and types of the six-axis sliding median unit.
// Used by the lane, merge and top-level modules; depends on nothing.
package sfmu_pkg;

    localparam int NUM_CH          = 6;
    localparam int DEF_WINDOW      = 10;
    localparam int DEF_SAMPLE_BITS = 24;
    localparam int HELD_BITS       = 4;

    // Pipeline load strobes handed from the top level to every lane.
    typedef struct packed {
        logic shift;   // a new sample enters the window
        logic load1;   // the compare stage takes the window
        logic load2;   // the rank stage takes the compare results
    } sfmu_ctrl_t;

endpackage

@@ rtl/sfmu_lane.sv @@
// One channel of the median filter: sample window, pairwise compares, rank match.
// Depends on sfmu_pkg for the pipeline control struct.
module sfmu_lane #(
    parameter int WINDOW      = 10,
    parameter int SAMPLE_BITS = 24,
    parameter int CNT_W       = 4
) (
    input  logic                          aclk,
    input  sfmu_pkg::sfmu_ctrl_t          ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [CNT_W-1:0]              fill0,
    input  logic [CNT_W-1:0]              rank1,
    output logic [WINDOW-1:0]             hit,
    output logic signed [SAMPLE_BITS-1:0] val [WINDOW]
);
    import sfmu_pkg::*;

    // Window, newest sample in entry 0; entries at or beyond the fill count are unused.
    logic signed [SAMPLE_BITS-1:0] win_reg [WINDOW];

    logic signed [SAMPLE_BITS-1:0] val1_reg [WINDOW];
    logic [WINDOW-1:0]             vld1_reg;
    logic [WINDOW-1:0]             lt_reg [WINDOW];
    logic [WINDOW-1:0]             le_reg [WINDOW];
    logic [WINDOW-1:0]             vld0;
    logic [WINDOW-1:0]             lt_next [WINDOW];
    logic [WINDOW-1:0]             le_next [WINDOW];

    logic signed [SAMPLE_BITS-1:0] val2_reg [WINDOW];
    logic [WINDOW-1:0]             hit_reg;
    logic [WINDOW-1:0]             hit_next;

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            win_reg[0] <= sample;
            for (int i = 1; i < WINDOW; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

    // Row i of lt/le marks the valid entries j below / not above entry i.
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            vld0[i] = (CNT_W'(i) < fill0);
        end
        for (int i = 0; i < WINDOW; i++) begin
            for (int j = 0; j < WINDOW; j++) begin
                lt_next[i][j] = vld0[j] && (win_reg[j] <  win_reg[i]);
                le_next[i][j] = vld0[j] && (win_reg[j] <= win_reg[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load1) begin
            val1_reg <= win_reg;
            vld1_reg <= vld0;
            lt_reg   <= lt_next;
            le_reg   <= le_next;
        end
    end

    // An entry holds the wanted rank when that rank falls within its run of equal values.
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            hit_next[i] = vld1_reg[i]
                && (CNT_W'($countones(lt_reg[i])) <= rank1)
                && (rank1 < CNT_W'($countones(le_reg[i])));
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load2) begin
            val2_reg <= val1_reg;
            hit_reg  <= hit_next;
        end
    end

    assign hit = hit_reg;
    assign val = val2_reg;

endmodule

@@ rtl/sfmu_merge.sv @@
// Merging stage: picks each lane's matched entry and holds the result transaction.
// Depends on sfmu_pkg for the channel count and the held-count width.
module sfmu_merge #(
    parameter int WINDOW      = 10,
    parameter int SAMPLE_BITS = 24,
    parameter int CNT_W       = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    input  logic [WINDOW-1:0]              lane_hit [sfmu_pkg::NUM_CH],
    input  logic signed [SAMPLE_BITS-1:0]  lane_val [sfmu_pkg::NUM_CH][WINDOW],
    input  logic [CNT_W-1:0]               cnt,
    output logic                           take,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_BITS-1:0]  median [sfmu_pkg::NUM_CH],
    output logic [sfmu_pkg::HELD_BITS-1:0] held
);
    import sfmu_pkg::*;

    logic                          valid_reg;
    logic signed [SAMPLE_BITS-1:0] median_reg [NUM_CH];
    logic signed [SAMPLE_BITS-1:0] median_next [NUM_CH];
    logic [HELD_BITS-1:0]          held_reg;
    logic [CNT_W+HELD_BITS-1:0]    held_wide;

    assign take      = !valid_reg || out_ready;
    assign held_wide = {{HELD_BITS{1'b0}}, cnt};

    // At least one entry of each lane matches, and all matching entries hold the same
    // value, so an OR of gated entries selects it.
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            median_next[c] = '0;
            for (int i = 0; i < WINDOW; i++) begin
                median_next[c] = median_next[c]
                    | (lane_val[c][i] & {SAMPLE_BITS{lane_hit[c][i]}});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && in_valid) begin
            median_reg <= median_next;
            held_reg   <= held_wide[HELD_BITS-1:0];
        end
    end

    assign out_valid = valid_reg;
    assign median    = median_reg;
    assign held      = held_reg;

endmodule

@@ rtl/six_axis_sliding_median_unit.sv @@
// Top level of the six-axis sliding-window median filter.
// Depends on sfmu_pkg, sfmu_lane, sfmu_merge and the assertion macro header.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+-----------------------------------------------
//  input   | s_valid / s_ready  | s_force_{x,y,z}, s_moment_{x,y,z}
//  result  | m_valid / m_ready  | m_median_force_{x,y,z}, m_median_moment_{x,y,z},
//          |                    | m_samples_held
//
// One transaction is accepted per cycle and one result comes out per cycle while m_ready stays high.
// A result becomes valid once its input has gone through, in turn, the window update at
// the edge that accepts it, then the compare, rank match and output register loads.
// Each stage advances on its own, so bubbles close up behind a stalled result;
// four transactions are held before s_ready falls.
// Reset empties the pipeline and clears the fill count; window contents are kept.
`include "six_axis_sliding_median_unit_defines.svh"

module six_axis_sliding_median_unit #(
    parameter int WINDOW      = sfmu_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = sfmu_pkg::DEF_SAMPLE_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_BITS-1:0]  s_force_x,
    input  logic signed [SAMPLE_BITS-1:0]  s_force_y,
    input  logic signed [SAMPLE_BITS-1:0]  s_force_z,
    input  logic signed [SAMPLE_BITS-1:0]  s_moment_x,
    input  logic signed [SAMPLE_BITS-1:0]  s_moment_y,
    input  logic signed [SAMPLE_BITS-1:0]  s_moment_z,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_BITS-1:0]  m_median_force_x,
    output logic signed [SAMPLE_BITS-1:0]  m_median_force_y,
    output logic signed [SAMPLE_BITS-1:0]  m_median_force_z,
    output logic signed [SAMPLE_BITS-1:0]  m_median_moment_x,
    output logic signed [SAMPLE_BITS-1:0]  m_median_moment_y,
    output logic signed [SAMPLE_BITS-1:0]  m_median_moment_z,
    output logic [sfmu_pkg::HELD_BITS-1:0] m_samples_held
);
    import sfmu_pkg::*;

    // Counts run from zero to WINDOW inclusive.
    localparam int CNT_W = $clog2(WINDOW + 1);

    sfmu_ctrl_t ctrl;

    // Stage valid flags: stage 0 is the window itself, 1 the compare, 2 the rank match.
    logic v0_reg, v1_reg, v2_reg;
    logic rdy0, rdy1, rdy2, rdy3;

    // Samples held after the newest accepted transaction, and its copies down the pipe.
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [CNT_W-1:0] cnt1_reg;
    logic [CNT_W-1:0] cnt2_reg;

    logic signed [SAMPLE_BITS-1:0] s_sample [NUM_CH];
    logic [WINDOW-1:0]             lane_hit [NUM_CH];
    logic signed [SAMPLE_BITS-1:0] lane_val [NUM_CH][WINDOW];
    logic signed [SAMPLE_BITS-1:0] median [NUM_CH];

    assign s_sample[0] = s_force_x;
    assign s_sample[1] = s_force_y;
    assign s_sample[2] = s_force_z;
    assign s_sample[3] = s_moment_x;
    assign s_sample[4] = s_moment_y;
    assign s_sample[5] = s_moment_z;

    // A stage can load when it is empty or its transaction moves on in the same cycle.
    assign rdy2       = !v2_reg || rdy3;
    assign rdy1       = !v1_reg || rdy2;
    assign rdy0       = !v0_reg || rdy1;
    assign s_ready    = rdy0;
    assign ctrl.shift = s_valid && rdy0;
    assign ctrl.load1 = v0_reg && rdy1;
    assign ctrl.load2 = v1_reg && rdy2;

    // The fill count saturates once the window is full; the oldest sample then drops out.
    assign fill_next = (fill_reg == CNT_W'(WINDOW)) ? fill_reg : fill_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            fill_reg <= '0;
        end else begin
            if (ctrl.shift) begin
                v0_reg   <= 1'b1;
                fill_reg <= fill_next;
            end else if (ctrl.load1) begin
                v0_reg <= 1'b0;
            end
            if (ctrl.load1) begin
                v1_reg <= 1'b1;
            end else if (ctrl.load2) begin
                v1_reg <= 1'b0;
            end
            if (ctrl.load2) begin
                v2_reg <= 1'b1;
            end else if (rdy3) begin
                v2_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load1) begin
            cnt1_reg <= fill_reg;
        end
        if (ctrl.load2) begin
            cnt2_reg <= cnt1_reg;
        end
    end

    // One lane per axis; each ranks its own window against the floor(count/2) target.
    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        sfmu_lane #(
            .WINDOW      (WINDOW),
            .SAMPLE_BITS (SAMPLE_BITS),
            .CNT_W       (CNT_W)
        ) u_lane (
            .aclk   (aclk),
            .ctrl   (ctrl),
            .sample (s_sample[c]),
            .fill0  (fill_reg),
            .rank1  (cnt1_reg >> 1),
            .hit    (lane_hit[c]),
            .val    (lane_val[c])
        );
    end

    sfmu_merge #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v2_reg),
        .lane_hit  (lane_hit),
        .lane_val  (lane_val),
        .cnt       (cnt2_reg),
        .take      (rdy3),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .median    (median),
        .held      (m_samples_held)
    );

    assign m_median_force_x  = median[0];
    assign m_median_force_y  = median[1];
    assign m_median_force_z  = median[2];
    assign m_median_moment_x = median[3];
    assign m_median_moment_y = median[4];
    assign m_median_moment_z = median[5];

    // The fill count never passes the window size.
    `SFMU_ASSERT_NOW(a_fill_range, aclk, aresetn, 1'b1, fill_reg <= CNT_W'(WINDOW))
    // Every accepted transaction below a full window adds exactly one sample.
    `SFMU_ASSERT_NEXT(a_fill_step, aclk, aresetn,
        ctrl.shift && (fill_reg != CNT_W'(WINDOW)), fill_reg == CNT_W'($past(fill_reg) + 1'b1))
    // A transaction in the rank stage always ranks at least one sample.
    `SFMU_ASSERT_NOW(a_rank_nonempty, aclk, aresetn, v2_reg, cnt2_reg != '0)
    // A compare-stage transaction blocked downstream is not dropped.
    `SFMU_ASSERT_NEXT(a_stall_hold, aclk, aresetn, v1_reg && !rdy2, v1_reg)
    // An empty window stage always takes input.
    `SFMU_ASSERT_NOW(a_ready_empty, aclk, aresetn, !v0_reg, s_ready)

endmodule
